### src/i2d_pkg.sv
// i2d_pkg: shared types and constants for the int64 to decimal text converter.
// Used by the digit cell, the top level and the checker. No dependencies.
`timescale 1ns / 1ps

package i2d_pkg;

   // Default for the largest zero-padded digit count
   localparam int I2D_MAX_PAD = 32;

   // 2^64 - 1 has 20 decimal digits
   localparam int NUM_DIGITS = 20;
   localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
   localparam int NDIG_W = $clog2(NUM_DIGITS + 1);

   // Magnitude bits and bits shifted into the digit chain per cycle
   localparam int MAG_W = 64;
   localparam int BITS_PER_STEP = 2;
   localparam int CONV_STEPS = MAG_W / BITS_PER_STEP;
   localparam int CONV_CNT_W = $clog2(CONV_STEPS);

   // Character codes
   localparam logic [6:0] CH_ZERO = 7'd48;
   localparam logic [6:0] CH_MINUS = 7'd45;

   typedef struct packed {
      logic signed [63:0] value;
      logic [5:0] pad_width;
   } req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic is_last;
   } rsp_type;

   // Control common to every digit cell
   typedef struct packed {
      logic clear;
      logic conv;
      logic shift;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_NORM,
      ST_SIGN,
      ST_ZERO,
      ST_DIGIT
   } state_type;

endpackage

### src/i2d_cell.sv
// i2d_cell: one BCD digit of the shift-and-add-3 chain, two bits per cycle.
// Also shifts its digit up the chain for output. Depends on i2d_pkg.
`timescale 1ns / 1ps

module i2d_cell
   import i2d_pkg::*;
(
   input  logic clock,
   input  cell_ctl_type ctl,
   input  logic cin1,
   input  logic cin2,
   input  logic [3:0] digit_in,
   output logic cout1,
   output logic cout2,
   output logic [3:0] digit
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in_nxt;
   logic [3:0] adj0;
   logic [3:0] step1;
   logic [3:0] adj1;
   logic [3:0] step2;

   // add 3 when the digit would reach 10 or more after doubling
   function automatic logic [3:0] add3(input logic [3:0] d);
      return (d >= 4'd5) ? d + 4'd3 : d;
   endfunction

   // two doubling steps; carries go to the next higher digit
   always_comb begin
      adj0 = add3(digit_ff);
      cout1 = adj0[3];
      step1 = {adj0[2:0], cin1};
      adj1 = add3(step1);
      cout2 = adj1[3];
      step2 = {adj1[2:0], cin2};
   end

   always_comb begin
      digit_in_nxt = digit_ff;
      if (ctl.clear) begin
         digit_in_nxt = 4'd0;
      end else if (ctl.conv) begin
         digit_in_nxt = step2;
      end else if (ctl.shift) begin
         digit_in_nxt = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_nxt;
   end

   assign digit = digit_ff;

endmodule

### src/int64_to_decimal_chars.sv
// int64_to_decimal_chars: signed 64-bit integer to zero-padded decimal characters.
// Uses i2d_pkg and a chain of i2d_cell digit cells.
`timescale 1ns / 1ps
//
// Usage:
//   req channel (req_valid/req_ready/req_data): one item = value + pad_width.
//   rsp channel (rsp_valid/rsp_ready/rsp_data): one character per item,
//   '-' if negative, leading '0's up to pad_width digits (saturated at
//   MAX_PAD), then the digits most significant first; is_last marks the end.
//   Conversion: a row of 20 BCD digit cells, two magnitude bits per cycle.
//   Leading zero digits are then shifted out, one per cycle, and the digits
//   leave from the top cell; all characters leave one per cycle through the
//   output register while there is no stall on rsp.
//   req_ready is high only between items; the next item is taken while the
//   last character still waits in the output register.
//   A stalled receiver holds the output register and pauses emission.
//   Reset (synchronous) returns to idle and drops rsp_valid.
//
module int64_to_decimal_chars
   import i2d_pkg::*;
#(
   parameter int MAX_PAD = I2D_MAX_PAD
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);

   localparam int PAD_W = $clog2(MAX_PAD + 1);

   state_type state_ff, state_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [PAD_W-1:0] pad_ff, pad_in;
   logic [PAD_W-1:0] zcnt_ff, zcnt_in;
   logic [CONV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NDIG_W-1:0] ndig_ff, ndig_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   cell_ctl_type cell_ctl;
   logic out_free;
   logic [PAD_W-1:0] pad_sat;
   logic [PAD_W-1:0] ndig_ext;
   logic [PAD_W-1:0] zeros;
   logic [3:0] top_digit;

   logic cout1 [NUM_DIGITS];
   logic cout2 [NUM_DIGITS];
   logic [3:0] digits [NUM_DIGITS];

   // digit chain: cell 0 takes magnitude bits, each cell feeds the one above
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         i2d_cell u_cell (
            .clock    (clock),
            .ctl      (cell_ctl),
            .cin1     (mag_ff[MAG_W-1]),
            .cin2     (mag_ff[MAG_W-2]),
            .digit_in (4'd0),
            .cout1    (cout1[i]),
            .cout2    (cout2[i]),
            .digit    (digits[i])
         );
      end else begin : g_rest
         i2d_cell u_cell (
            .clock    (clock),
            .ctl      (cell_ctl),
            .cin1     (cout1[i-1]),
            .cin2     (cout2[i-1]),
            .digit_in (digits[i-1]),
            .cout1    (cout1[i]),
            .cout2    (cout2[i]),
            .digit    (digits[i])
         );
      end
   end

   assign top_digit = digits[NUM_DIGITS-1];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // pad saturation and leading zero count
   always_comb begin
      pad_sat = (req_data.pad_width > 6'(MAX_PAD)) ? PAD_W'(MAX_PAD)
                                                   : PAD_W'(req_data.pad_width);
      ndig_ext = PAD_W'(ndig_ff);
      zeros = (pad_ff > ndig_ext) ? pad_ff - ndig_ext : '0;
   end

   // sequencer: convert, strip leading zero digits, emit characters
   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      pad_in = pad_ff;
      zcnt_in = zcnt_ff;
      cnt_in = cnt_ff;
      ndig_in = ndig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      cell_ctl = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               neg_in = req_data.value[MAG_W-1];
               mag_in = req_data.value[MAG_W-1] ? (~req_data.value) + 64'd1
                                                : req_data.value;
               pad_in = pad_sat;
               cnt_in = '0;
               cell_ctl.clear = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cell_ctl.conv = 1'b1;
            mag_in = mag_ff << BITS_PER_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CONV_CNT_W'(CONV_STEPS - 1)) begin
               ndig_in = NDIG_W'(NUM_DIGITS);
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (top_digit == 4'd0 && ndig_ff > NDIG_W'(1)) begin
               cell_ctl.shift = 1'b1;
               ndig_in = ndig_ff - 1'b1;
            end else begin
               zcnt_in = zeros;
               if (neg_ff) begin
                  state_in = ST_SIGN;
               end else if (zeros != '0) begin
                  state_in = ST_ZERO;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '{char_code: CH_MINUS, is_last: 1'b0};
               state_in = (zcnt_ff != '0) ? ST_ZERO : ST_DIGIT;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '{char_code: CH_ZERO, is_last: 1'b0};
               zcnt_in = zcnt_ff - 1'b1;
               if (zcnt_ff == PAD_W'(1)) begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '{char_code: CH_ZERO + {3'd0, top_digit},
                               is_last: (ndig_ff == NDIG_W'(1))};
               cell_ctl.shift = 1'b1;
               ndig_in = ndig_ff - 1'b1;
               if (ndig_ff == NDIG_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      pad_ff <= pad_in;
      zcnt_ff <= zcnt_in;
      cnt_ff <= cnt_in;
      ndig_ff <= ndig_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### src/i2d_checker.sv
// i2d_sva: port-level assertions for int64_to_decimal_chars, bound to it.
// Depends on i2d_pkg.
`timescale 1ns / 1ps

module i2d_sva
   import i2d_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_data
);

   // a waiting character holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // one item at a time: no second accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accept");

   // between items only the final character may be pending
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_data.is_last)
      else $error("ready for a new item with text still pending");

   // only '-' and digits are ever emitted
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.char_code == CH_MINUS) ||
                    ((rsp_data.char_code >= CH_ZERO) &&
                     (rsp_data.char_code <= CH_ZERO + 7'd9)))
      else $error("character code out of range");

endmodule

bind int64_to_decimal_chars i2d_sva u_i2d_sva (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
